// ----- hdl/tokscan_pkg.sv -----
// Package for the token scanner: result record, scan modes, token class codes,
// keyword tables and character codes. No dependencies.

package tokscan_pkg;

  localparam int MaxTokenLen = 63;
  localparam int LenCap      = (MaxTokenLen < 63) ? MaxTokenLen : 63;
  localparam logic [5:0] LenCapW = 6'(LenCap);

  // Token class codes
  localparam logic [4:0] ClsId       = 5'd0;
  localparam logic [4:0] ClsIntConst = 5'd9;
  localparam logic [4:0] ClsFltConst = 5'd10;
  localparam logic [4:0] ClsAddOp    = 5'd11;
  localparam logic [4:0] ClsEqOp     = 5'd12;
  localparam logic [4:0] ClsAssign   = 5'd13;
  localparam logic [4:0] ClsAnd      = 5'd14;
  localparam logic [4:0] ClsOr       = 5'd15;
  localparam logic [4:0] ClsCompOp   = 5'd16;
  localparam logic [4:0] ClsMultOp   = 5'd17;
  localparam logic [4:0] ClsStmtEnd  = 5'd18;
  localparam logic [4:0] ClsOpen     = 5'd19;
  localparam logic [4:0] ClsClose    = 5'd20;
  localparam logic [4:0] ClsComma    = 5'd21;
  localparam logic [4:0] ClsOther    = 5'd22;
  localparam logic [4:0] ClsEnd      = 5'd23;

  // Character codes
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChUpA    = 8'd65;
  localparam logic [7:0] ChUpZ    = 8'd90;
  localparam logic [7:0] ChLoA    = 8'd97;
  localparam logic [7:0] ChLoZ    = 8'd122;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChPct    = 8'h25;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;

  // Keywords, class = index + 1
  typedef logic [0:7][7:0] kw_text_t;
  localparam kw_text_t KwText [0:7] = '{
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"p", "r", "o", "g", "r", "a", "m", 8'h00},
    '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KwLen [0:7] = '{3'd5, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd5, 3'd3};

  typedef enum logic [8:0] {
    MODE_IDLE  = 9'b000000001,
    MODE_IDENT = 9'b000000010,
    MODE_INT   = 9'b000000100,
    MODE_FLOAT = 9'b000001000,
    MODE_COLON = 9'b000010000,
    MODE_AMP   = 9'b000100000,
    MODE_BAR   = 9'b001000000,
    MODE_BANG  = 9'b010000000,
    MODE_COMP  = 9'b100000000
  } scan_mode_t;

  typedef struct packed {
    logic [4:0] token_class;
    logic [5:0] token_length;
    logic       length_overflow;
    logic       last_of_run;
  } result_t;

endpackage

// ----- hdl/tokscan_if.sv -----
// Channel interfaces for the token scanner: character requests in, token
// results out. No dependencies.

interface tokscan_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface tokscan_tok_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_class;
  logic [5:0] token_length;
  logic       length_overflow;
  logic       last_of_run;

  modport source (output valid, output token_class, output token_length,
                  output length_overflow, output last_of_run, input ready);
  modport sink (input valid, input token_class, input token_length,
                input length_overflow, input last_of_run, output ready);
endinterface

// ----- hdl/token_scanner.sv -----
// Token scanner top level: per-character scan state and a four-entry result queue.
// Depends on tokscan_pkg and the channel interfaces in tokscan_if.sv.
//
//  channel  dir  payload                                         handshake
//  chars    in   ch[7:0], end_of_input                          valid/ready
//  tokens   out  token_class[4:0], token_length[5:0],           valid/ready
//                length_overflow, last_of_run
//
// One character request is taken per cycle while chars.ready is high; its results
// are in the queue the next cycle. A request gives 0, 1 or 2 results and the queue
// drains one per cycle while tokens.ready is high, so two-result runs stall chars.
// chars.ready drops when fewer than two queue slots are free.
// rst (synchronous) returns the scanner to idle between tokens and empties the queue.

module token_scanner (
  input  logic               clk,
  input  logic               rst,
  tokscan_char_if.sink       chars,
  tokscan_tok_if.source      tokens
);

  tokscan_pkg::scan_mode_t mode, mode_next;
  logic [5:0] run_length, run_length_next;
  logic [7:0] keyword_mask, keyword_mask_next;
  logic       overflow_seen, overflow_seen_next;

  tokscan_pkg::result_t queue [0:3];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  logic       accept, pop;
  logic [7:0] c;
  logic       is_sep, is_letter, is_digit;
  logic [7:0] mask_upd, mask_first;
  logic [4:0] kw_cls;
  logic       kw_hit;
  tokscan_pkg::result_t flush_res, start_res, pair_res, end_res, r0, r1;
  logic       flush_pend, start_emit, pair_hit;
  tokscan_pkg::scan_mode_t start_mode;
  logic [5:0] start_len;
  logic [1:0] n_res;

  assign c         = chars.ch;
  assign accept    = chars.valid && chars.ready;
  assign pop       = tokens.valid && tokens.ready;
  assign is_sep    = (c == tokscan_pkg::ChSpace) || (c == tokscan_pkg::ChTab) ||
                     (c == tokscan_pkg::ChNl);
  assign is_letter = ((c >= tokscan_pkg::ChUpA) && (c <= tokscan_pkg::ChUpZ)) ||
                     ((c >= tokscan_pkg::ChLoA) && (c <= tokscan_pkg::ChLoZ));
  assign is_digit  = (c >= tokscan_pkg::ChZero) && (c <= tokscan_pkg::ChNine);

  // Keyword candidate mask, one compare per keyword
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask_upd[k] = keyword_mask[k] &&
                    (run_length < {3'b000, tokscan_pkg::KwLen[k]}) &&
                    (tokscan_pkg::KwText[k][run_length[2:0]] == c);
      mask_first[k] = (tokscan_pkg::KwText[k][0] == c);
    end
  end

  // Lowest-index keyword whose length matches wins
  always_comb begin
    kw_hit = 1'b0;
    kw_cls = tokscan_pkg::ClsId;
    for (int k = 7; k >= 0; k--) begin
      if (keyword_mask[k] && ({3'b000, tokscan_pkg::KwLen[k]} == run_length)) begin
        kw_hit = 1'b1;
        kw_cls = 5'(k + 1);
      end
    end
  end

  // Token pending in the state, as emitted on flush
  always_comb begin
    flush_pend = (mode != tokscan_pkg::MODE_IDLE);
    flush_res = '0;
    flush_res.token_length = run_length;
    flush_res.length_overflow = overflow_seen;
    unique case (mode)
      tokscan_pkg::MODE_IDENT:
        flush_res.token_class = (kw_hit && !overflow_seen) ? kw_cls : tokscan_pkg::ClsId;
      tokscan_pkg::MODE_INT:   flush_res.token_class = tokscan_pkg::ClsIntConst;
      tokscan_pkg::MODE_FLOAT: flush_res.token_class = tokscan_pkg::ClsFltConst;
      tokscan_pkg::MODE_COMP:  flush_res.token_class = tokscan_pkg::ClsCompOp;
      default:                 flush_res.token_class = tokscan_pkg::ClsOther;
    endcase
  end

  // New token started by this character
  always_comb begin
    start_mode = tokscan_pkg::MODE_IDLE;
    start_len  = 6'd1;
    start_emit = 1'b0;
    start_res  = '0;
    start_res.token_length = 6'd1;
    start_res.token_class  = tokscan_pkg::ClsOther;
    priority if (is_sep) begin
      start_len = 6'd0;
    end else if (is_letter) begin
      start_mode = tokscan_pkg::MODE_IDENT;
    end else if (is_digit) begin
      start_mode = tokscan_pkg::MODE_INT;
    end else begin
      priority case (c)
        tokscan_pkg::ChColon: start_mode = tokscan_pkg::MODE_COLON;
        tokscan_pkg::ChAmp:   start_mode = tokscan_pkg::MODE_AMP;
        tokscan_pkg::ChBar:   start_mode = tokscan_pkg::MODE_BAR;
        tokscan_pkg::ChBang:  start_mode = tokscan_pkg::MODE_BANG;
        tokscan_pkg::ChLt, tokscan_pkg::ChGt: start_mode = tokscan_pkg::MODE_COMP;
        default: begin
          start_len  = 6'd0;
          start_emit = 1'b1;
          priority case (c)
            tokscan_pkg::ChPlus, tokscan_pkg::ChMinus:
              start_res.token_class = tokscan_pkg::ClsAddOp;
            tokscan_pkg::ChEq: start_res.token_class = tokscan_pkg::ClsEqOp;
            tokscan_pkg::ChStar, tokscan_pkg::ChSlash, tokscan_pkg::ChPct:
              start_res.token_class = tokscan_pkg::ClsMultOp;
            tokscan_pkg::ChSemi:   start_res.token_class = tokscan_pkg::ClsStmtEnd;
            tokscan_pkg::ChLParen: start_res.token_class = tokscan_pkg::ClsOpen;
            tokscan_pkg::ChRParen: start_res.token_class = tokscan_pkg::ClsClose;
            tokscan_pkg::ChComma:  start_res.token_class = tokscan_pkg::ClsComma;
            default:               start_res.token_class = tokscan_pkg::ClsOther;
          endcase
        end
      endcase
    end
  end

  // Second character of a two-character operator
  always_comb begin
    pair_hit = 1'b0;
    pair_res = '0;
    pair_res.token_length = 6'd2;
    pair_res.token_class  = tokscan_pkg::ClsOther;
    priority if (mode == tokscan_pkg::MODE_COLON && c == tokscan_pkg::ChEq) begin
      pair_hit = 1'b1;
      pair_res.token_class = tokscan_pkg::ClsAssign;
    end else if (mode == tokscan_pkg::MODE_AMP && c == tokscan_pkg::ChAmp) begin
      pair_hit = 1'b1;
      pair_res.token_class = tokscan_pkg::ClsAnd;
    end else if (mode == tokscan_pkg::MODE_BAR && c == tokscan_pkg::ChBar) begin
      pair_hit = 1'b1;
      pair_res.token_class = tokscan_pkg::ClsOr;
    end else if (mode == tokscan_pkg::MODE_BANG && c == tokscan_pkg::ChEq) begin
      pair_hit = 1'b1;
      pair_res.token_class = tokscan_pkg::ClsEqOp;
    end else if (mode == tokscan_pkg::MODE_COMP && c == tokscan_pkg::ChEq) begin
      pair_hit = 1'b1;
      pair_res.token_class = tokscan_pkg::ClsCompOp;
    end
  end

  always_comb begin
    end_res = '0;
    end_res.token_class = tokscan_pkg::ClsEnd;
  end

  // Next state and results of one request
  always_comb begin
    mode_next          = mode;
    run_length_next    = run_length;
    keyword_mask_next  = keyword_mask;
    overflow_seen_next = overflow_seen;
    n_res = 2'd0;
    r0 = '0;
    r1 = '0;
    priority if (chars.end_of_input) begin
      mode_next          = tokscan_pkg::MODE_IDLE;
      run_length_next    = 6'd0;
      keyword_mask_next  = 8'hFF;
      overflow_seen_next = 1'b0;
      if (flush_pend) begin
        r0 = flush_res;
        r1 = end_res;
        n_res = 2'd2;
      end else begin
        r0 = end_res;
        n_res = 2'd1;
      end
    end else if ((mode == tokscan_pkg::MODE_IDENT && is_letter) ||
                 ((mode == tokscan_pkg::MODE_INT || mode == tokscan_pkg::MODE_FLOAT) &&
                  is_digit) ||
                 (mode == tokscan_pkg::MODE_INT && c == tokscan_pkg::ChDot)) begin
      if (mode == tokscan_pkg::MODE_IDENT) begin
        keyword_mask_next = mask_upd;
      end
      if (mode == tokscan_pkg::MODE_INT && c == tokscan_pkg::ChDot) begin
        mode_next = tokscan_pkg::MODE_FLOAT;
      end
      if (run_length >= tokscan_pkg::LenCapW) begin
        overflow_seen_next = 1'b1;
      end else begin
        run_length_next = run_length + 6'd1;
      end
    end else if (pair_hit) begin
      mode_next          = tokscan_pkg::MODE_IDLE;
      run_length_next    = 6'd0;
      keyword_mask_next  = 8'hFF;
      overflow_seen_next = 1'b0;
      r0 = pair_res;
      n_res = 2'd1;
    end else begin
      mode_next          = start_mode;
      run_length_next    = start_len;
      keyword_mask_next  = is_letter ? mask_first : 8'hFF;
      overflow_seen_next = 1'b0;
      if (flush_pend) begin
        r0 = flush_res;
        r1 = start_res;
        n_res = start_emit ? 2'd2 : 2'd1;
      end else if (start_emit) begin
        r0 = start_res;
        n_res = 2'd1;
      end
    end
    r0.last_of_run = (n_res == 2'd1);
    r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tokscan_pkg::MODE_IDLE;
      run_length    <= 6'd0;
      keyword_mask  <= 8'hFF;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      run_length    <= run_length_next;
      keyword_mask  <= keyword_mask_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      queue[wptr] <= r0;
    end
    if (accept && n_res == 2'd2) begin
      queue[wptr + 2'd1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (accept) begin
        wptr <= wptr + n_res;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  assign chars.ready            = (count <= 3'd2);
  assign tokens.valid           = (count != 3'd0);
  assign tokens.token_class     = queue[rptr].token_class;
  assign tokens.token_length    = queue[rptr].token_length;
  assign tokens.length_overflow = queue[rptr].length_overflow;
  assign tokens.last_of_run     = queue[rptr].last_of_run;

endmodule

// ----- tb/token_checker.sv -----
// Token scanner checker: watches the character and token channels, predicts
// the token results of each accepted character request and compares them.
// Depends on tokscan_pkg and the channel interfaces in tokscan_if.sv.

module token_checker (
  input  logic    clk,
  input  logic    rst,
  tokscan_char_if chars,
  tokscan_tok_if  tokens,
  output int      mismatch_count,
  output int      due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LenLimit = (tokscan_pkg::MaxTokenLen < 63) ? tokscan_pkg::MaxTokenLen : 63;

  string kw_spell [8] = '{"while", "if", "int", "else", "float", "program", "begin", "end"};

  tokscan_pkg::scan_mode_t mode;
  logic [5:0]              run_len;
  logic [7:0]              kw_mask;
  logic                    run_ovf;
  tokscan_pkg::result_t    made [2];
  int                      n_made;
  tokscan_pkg::result_t    tokens_due [$];
  int                      mismatches = 0;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= tokscan_pkg::ChUpA && c <= tokscan_pkg::ChUpZ) ||
           (c >= tokscan_pkg::ChLoA && c <= tokscan_pkg::ChLoZ);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= tokscan_pkg::ChZero && c <= tokscan_pkg::ChNine;
  endfunction

  task automatic reset_scan();
    mode = tokscan_pkg::MODE_IDLE;
    run_len = '0;
    kw_mask = 8'hFF;
    run_ovf = 1'b0;
  endtask

  task automatic note_token(input logic [4:0] cls, input logic [5:0] len, input logic ovf);
    tokscan_pkg::result_t r;
    r.token_class = cls;
    r.token_length = len;
    r.length_overflow = ovf;
    r.last_of_run = 1'b0;
    made[n_made] = r;
    n_made++;
  endtask

  // drop every keyword whose spelling does not have c at the current position
  task automatic narrow_keywords(input logic [7:0] c);
    for (int k = 0; k < 8; k++) begin
      if (run_len >= kw_spell[k].len() || kw_spell[k][run_len] != c)
        kw_mask[k] = 1'b0;
    end
  endtask

  task automatic lengthen();
    if (run_len >= LenLimit)
      run_ovf = 1'b1;
    else
      run_len++;
  endtask

  task automatic close_token();
    logic [4:0] cls;
    cls = tokscan_pkg::ClsOther;
    if (mode != tokscan_pkg::MODE_IDLE) begin
      case (mode)
        tokscan_pkg::MODE_IDENT: begin
          cls = tokscan_pkg::ClsId;
          // lowest keyword index wins
          if (!run_ovf) begin
            for (int k = 7; k >= 0; k--) begin
              if (kw_mask[k] && kw_spell[k].len() == run_len)
                cls = 5'(k + 1);
            end
          end
        end
        tokscan_pkg::MODE_INT:   cls = tokscan_pkg::ClsIntConst;
        tokscan_pkg::MODE_FLOAT: cls = tokscan_pkg::ClsFltConst;
        tokscan_pkg::MODE_COMP:  cls = tokscan_pkg::ClsCompOp;
        default:                 cls = tokscan_pkg::ClsOther;
      endcase
      note_token(cls, run_len, run_ovf);
      reset_scan();
    end
  endtask

  task automatic start_token(input logic [7:0] c);
    reset_scan();
    if (c == tokscan_pkg::ChSpace || c == tokscan_pkg::ChTab || c == tokscan_pkg::ChNl) begin
    end else if (is_alpha(c)) begin
      narrow_keywords(c);
      run_len = 6'd1;
      mode = tokscan_pkg::MODE_IDENT;
    end else if (is_num(c)) begin
      run_len = 6'd1;
      mode = tokscan_pkg::MODE_INT;
    end else begin
      case (c)
        tokscan_pkg::ChColon: begin
          mode = tokscan_pkg::MODE_COLON;
          run_len = 6'd1;
        end
        tokscan_pkg::ChAmp: begin
          mode = tokscan_pkg::MODE_AMP;
          run_len = 6'd1;
        end
        tokscan_pkg::ChBar: begin
          mode = tokscan_pkg::MODE_BAR;
          run_len = 6'd1;
        end
        tokscan_pkg::ChBang: begin
          mode = tokscan_pkg::MODE_BANG;
          run_len = 6'd1;
        end
        tokscan_pkg::ChLt, tokscan_pkg::ChGt: begin
          mode = tokscan_pkg::MODE_COMP;
          run_len = 6'd1;
        end
        tokscan_pkg::ChPlus, tokscan_pkg::ChMinus:
          note_token(tokscan_pkg::ClsAddOp, 6'd1, 1'b0);
        tokscan_pkg::ChEq:
          note_token(tokscan_pkg::ClsEqOp, 6'd1, 1'b0);
        tokscan_pkg::ChStar, tokscan_pkg::ChSlash, tokscan_pkg::ChPct:
          note_token(tokscan_pkg::ClsMultOp, 6'd1, 1'b0);
        tokscan_pkg::ChSemi:
          note_token(tokscan_pkg::ClsStmtEnd, 6'd1, 1'b0);
        tokscan_pkg::ChLParen:
          note_token(tokscan_pkg::ClsOpen, 6'd1, 1'b0);
        tokscan_pkg::ChRParen:
          note_token(tokscan_pkg::ClsClose, 6'd1, 1'b0);
        tokscan_pkg::ChComma:
          note_token(tokscan_pkg::ClsComma, 6'd1, 1'b0);
        default:
          note_token(tokscan_pkg::ClsOther, 6'd1, 1'b0);
      endcase
    end
  endtask

  // expected tokens for one character request, queued in order
  task automatic scan_char(input logic [7:0] c, input logic eoi);
    logic [4:0]           pair_cls;
    logic                 paired;
    tokscan_pkg::result_t r;
    n_made = 0;
    paired = 1'b1;
    pair_cls = tokscan_pkg::ClsOther;
    if (mode == tokscan_pkg::MODE_COLON && c == tokscan_pkg::ChEq)
      pair_cls = tokscan_pkg::ClsAssign;
    else if (mode == tokscan_pkg::MODE_AMP && c == tokscan_pkg::ChAmp)
      pair_cls = tokscan_pkg::ClsAnd;
    else if (mode == tokscan_pkg::MODE_BAR && c == tokscan_pkg::ChBar)
      pair_cls = tokscan_pkg::ClsOr;
    else if (mode == tokscan_pkg::MODE_BANG && c == tokscan_pkg::ChEq)
      pair_cls = tokscan_pkg::ClsEqOp;
    else if (mode == tokscan_pkg::MODE_COMP && c == tokscan_pkg::ChEq)
      pair_cls = tokscan_pkg::ClsCompOp;
    else
      paired = 1'b0;

    if (eoi) begin
      close_token();
      note_token(tokscan_pkg::ClsEnd, 6'd0, 1'b0);
    end else if (mode == tokscan_pkg::MODE_IDENT && is_alpha(c)) begin
      narrow_keywords(c);
      lengthen();
    end else if ((mode == tokscan_pkg::MODE_INT || mode == tokscan_pkg::MODE_FLOAT) &&
                 is_num(c)) begin
      lengthen();
    end else if (mode == tokscan_pkg::MODE_INT && c == tokscan_pkg::ChDot) begin
      lengthen();
      mode = tokscan_pkg::MODE_FLOAT;
    end else if (paired) begin
      note_token(pair_cls, 6'd2, 1'b0);
      reset_scan();
    end else begin
      close_token();
      start_token(c);
    end

    for (int i = 0; i < n_made; i++) begin
      r = made[i];
      r.last_of_run = (i == n_made - 1);
      tokens_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    tokscan_pkg::result_t got;
    tokscan_pkg::result_t want;
    if (rst) begin
      reset_scan();
      tokens_due.delete();
    end else begin
      // a token leaving now never belongs to a request taken at this edge
      if (tokens.valid && tokens.ready) begin
        got.token_class = tokens.token_class;
        got.token_length = tokens.token_length;
        got.length_overflow = tokens.length_overflow;
        got.last_of_run = tokens.last_of_run;
        if (tokens_due.size() == 0) begin
          mismatches++;
          $display(
              "%0t: unexpected token: expected none, got cls=%0d len=%0d ovf=%0b last=%0b",
              $time, got.token_class, got.token_length, got.length_overflow,
              got.last_of_run);
        end else begin
          want = tokens_due.pop_front();
          if (got.token_class !== want.token_class || got.token_length !== want.token_length ||
              got.length_overflow !== want.length_overflow ||
              got.last_of_run !== want.last_of_run) begin
            mismatches++;
            $display(
                "%0t: expected cls=%0d len=%0d ovf=%0b last=%0b, got cls=%0d len=%0d ovf=%0b last=%0b",
                $time, want.token_class, want.token_length, want.length_overflow,
                want.last_of_run, got.token_class, got.token_length,
                got.length_overflow, got.last_of_run);
          end
        end
      end
      if (chars.valid && chars.ready)
        scan_char(chars.ch, chars.end_of_input);
    end
    mismatch_count <= mismatches;
    due_count <= tokens_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the token scanner: clock, reset, character stimulus and
// token-side stalls in four pacing phases; verdict from token_checker.
// Depends on tokscan_pkg, tokscan_if.sv, token_scanner and token_checker.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 225;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   sent = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   due_count;

  string kw_words [8] = '{"while", "if", "int", "else", "float", "program", "begin", "end"};
  string op_words [22] = '{":=", "&&", "||", "!=", "<=", ">=", ":", "&", "|", "!", "<", ">",
                           "+", "-", "=", "*", "/", "%", ";", "(", ")", ","};

  tokscan_char_if chars_if();
  tokscan_tok_if  tokens_if();

  token_scanner DUT (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .tokens(tokens_if)
  );

  token_checker u_check (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .tokens(tokens_if),
    .mismatch_count(mismatch_count),
    .due_count(due_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    tokens_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'(tokscan_pkg::ChLoA + $urandom_range(25)) :
                               8'(tokscan_pkg::ChUpA + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(tokscan_pkg::ChZero + $urandom_range(9));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.ch <= c;
    chars_if.end_of_input <= eoi;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b0);
  endtask

  // at most one random lexeme, then maybe a separator
  task automatic send_lexeme();
    int    pick;
    int    len;
    string word;
    pick = $urandom_range(99);
    if (pick < 15) begin
      word = kw_words[$urandom_range(7)];
      case ($urandom_range(3))
        0: word = {word, "s"};
        1: word = word.substr(0, word.len() - 2);
        default: ;
      endcase
      send_text(word);
    end else if (pick < 35) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(70, 58) : $urandom_range(8, 1);
      repeat (len) send_char(rand_letter(), 1'b0);
    end else if (pick < 52) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(70, 58) : $urandom_range(5, 1);
      repeat (len) send_char(rand_digit(), 1'b0);
      if ($urandom_range(1)) begin
        send_char(tokscan_pkg::ChDot, 1'b0);
        repeat ($urandom_range(4)) send_char(rand_digit(), 1'b0);
        if ($urandom_range(7) == 0)
          send_char(tokscan_pkg::ChDot, 1'b0);
      end
    end else if (pick < 75) begin
      send_text(op_words[$urandom_range(21)]);
    end else if (pick < 85) begin
      send_char(8'($urandom_range(255)), 1'b0);
    end else if (pick < 89) begin
      send_char(8'($urandom_range(255)), 1'b1);
    end
    case ($urandom_range(4))
      0: send_char(tokscan_pkg::ChSpace, 1'b0);
      1: send_char(tokscan_pkg::ChTab, 1'b0);
      2: send_char(tokscan_pkg::ChNl, 1'b0);
      default: ;
    endcase
  endtask

  // hold off requests until every predicted token has come out
  task automatic settle();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  initial begin
    chars_if.valid <= 1'b0;
    chars_if.ch <= '0;
    chars_if.end_of_input <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      if (p == 0) begin
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        // keyword, letter/digit junctions, float ended by a second dot
        send_text("if x9y 2.5.");
        send_text(":=");
        // lone pair starters and comparison forms
        send_text("!&|<>=");
        send_text("+*;(),");
        send_char(8'hFF, 1'b1);
      end
      while (sent < (p + 1) * PhaseItems) send_lexeme();
      send_char(8'($urandom_range(255)), 1'b1);
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && due_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ----- token_scanner.f -----
hdl/tokscan_pkg.sv
hdl/tokscan_if.sv
hdl/token_scanner.sv
tb/token_checker.sv
tb/tb_top.sv
